>>> src/rhsel_pkg.sv
package rhsel_pkg;

    // Default sizing of the histogram store.
    localparam int ATTRIBUTES_DEF = 32;
    localparam int BUCKETS_DEF    = 64;
    localparam int COUNT_BITS_DEF = 24;

    // Field widths of one input item and one result item.
    localparam int ATTR_W     = 5;
    localparam int VALUE_W    = 16;
    localparam int POS_W      = 22;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;
    localparam int SUM_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;

    // Bucket width after reset.
    localparam logic [VALUE_W-1:0] BUCKET_WIDTH_RST = 16'd1024;

    // Largest position value.
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Item kinds carried on the slave-side tuser.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

endpackage

>>> src/range_histogram_selectivity.sv
// Channel   Direction  Signals                                  Contents
// s         in         i_s_tvalid o_s_tready i_s_tdata/tuser/tlast  add or query item
// m         out        o_m_tvalid i_m_tready o_m_tdata/tuser     position and empty flag
// cfg       in         i_cfg_valid o_cfg_ready i_cfg_data        bucket width
//
// One shared restoring divider, one quotient bit per cycle, sets the pace.
// An add item divides its low and high values, then updates each bucket it
// covers. A query pair divides its low value; the last pair adds a
// final divide when constraints exist. Items are taken only while idle.
// After reset a clearing pass writes ATTRIBUTES*BUCKETS entries, one per
// cycle, before the first item is taken. A stalled result waits in the
// output register; the block then holds its next result until it is taken.
module range_histogram_selectivity #(
    parameter int ATTRIBUTES = rhsel_pkg::ATTRIBUTES_DEF,
    parameter int BUCKETS    = rhsel_pkg::BUCKETS_DEF,
    parameter int COUNT_BITS = rhsel_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Slave side.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: attribute[4:0], low_value[20:5], high_value[36:21], zero fill.
    input  logic [rhsel_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: action.
    input  logic                           i_s_tuser,
    input  logic                           i_s_tlast,
    // Master side.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: position[21:0], zero fill.
    output logic [rhsel_pkg::M_TDATA_W-1:0] o_m_tdata,
    // tuser: no_constraints.
    output logic                           o_m_tuser,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rhsel_pkg::VALUE_W-1:0]  i_cfg_data
);

    localparam int DEPTH  = ATTRIBUTES * BUCKETS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = $clog2(BUCKETS);
    localparam int DQ_W   = rhsel_pkg::DIVIDEND_W;
    localparam int SUM_W  = rhsel_pkg::SUM_W;
    localparam int VAL_W  = rhsel_pkg::VALUE_W;
    localparam int POS_W  = rhsel_pkg::POS_W;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIV_LO, S_CAP_LO, S_DIV_HI, S_CAP_HI, S_UPD,
        S_DIV_QI, S_QRD, S_QACC, S_DIV_POS, S_OUT
    } t_state;

    // Bucket index from a 16-bit quotient, clamped to the last bucket.
    function automatic logic [IDX_W-1:0] clamp_idx(input logic [VAL_W-1:0] q);
        if (q > VAL_W'(BUCKETS - 1)) begin
            return IDX_W'(BUCKETS - 1);
        end
        return q[IDX_W-1:0];
    endfunction

    // Input fields.
    logic [rhsel_pkg::ATTR_W-1:0] w_attr;
    logic [VAL_W-1:0]             w_low;
    logic [VAL_W-1:0]             w_high;
    logic                         w_attr_ok;
    assign w_attr    = i_s_tdata[4:0];
    assign w_low     = i_s_tdata[20:5];
    assign w_high    = i_s_tdata[36:21];
    assign w_attr_ok = (32'(w_attr) < ATTRIBUTES);

    // Registers.
    t_state                r_state, n_state;
    logic [VAL_W-1:0]      r_bw;
    logic [ADDR_W-1:0]     r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]     r_base, n_base;
    logic [VAL_W-1:0]      r_high, n_high;
    logic                  r_last, n_last;
    logic                  r_qhit, n_qhit;
    logic                  r_zero, n_zero;
    logic [IDX_W-1:0]      r_start, n_start;
    logic [IDX_W-1:0]      r_end, n_end;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [SUM_W-1:0]      r_total, n_total;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [DQ_W-1:0]       r_dq, n_dq;
    logic [SUM_W-1:0]      r_dr, n_dr;
    logic [SUM_W-1:0]      r_dd, n_dd;
    logic [5:0]            r_dcnt, n_dcnt;
    logic                  r_m_valid, n_m_valid;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_flag, n_flag;

    // Histogram store and its port controls.
    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  w_we, w_re;
    logic [ADDR_W-1:0]     w_waddr, w_raddr;
    logic [COUNT_BITS-1:0] w_wdata;

    // Effective bucket width: zero acts as one.
    logic [VAL_W-1:0] w_eff_bw;
    assign w_eff_bw = (r_bw == '0) ? VAL_W'(1) : r_bw;

    // One restoring divide step on the shared divider.
    logic [SUM_W:0]   w_shl;
    logic [SUM_W+1:0] w_diff;
    logic             w_ge;
    assign w_shl  = {r_dr, r_dq[DQ_W-1]};
    assign w_diff = {1'b0, w_shl} - {2'b00, r_dd};
    assign w_ge   = ~w_diff[SUM_W+1];

    // Saturating sum of the running query and the bucket just read.
    logic [COUNT_BITS-1:0] w_hit;
    logic [SUM_W:0]        w_sum_wide;
    logic [SUM_W-1:0]      w_sum_sat;
    assign w_hit      = r_qhit ? r_rd_data : '0;
    assign w_sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(w_hit);
    assign w_sum_sat  = w_sum_wide[SUM_W] ? {SUM_W{1'b1}} : w_sum_wide[SUM_W-1:0];

    // Final quotient, saturated to the position range.
    logic [POS_W-1:0] w_pos_q;
    assign w_pos_q = (r_dq[DQ_W-1:POS_W] != '0) ? rhsel_pkg::POS_MAX : r_dq[POS_W-1:0];

    logic [IDX_W-1:0] w_qidx;
    assign w_qidx = clamp_idx(r_dq[VAL_W-1:0]);

    // Sequencer next-state and memory control.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_base     = r_base;
        n_high     = r_high;
        n_last     = r_last;
        n_qhit     = r_qhit;
        n_zero     = r_zero;
        n_start    = r_start;
        n_end      = r_end;
        n_idx      = r_idx;
        n_total    = r_total;
        n_sum      = r_sum;
        n_dq       = r_dq;
        n_dr       = r_dr;
        n_dd       = r_dd;
        n_dcnt     = r_dcnt;
        n_m_valid  = r_m_valid & ~i_m_tready;
        n_pos      = r_pos;
        n_flag     = r_flag;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = r_clr_addr;
        w_raddr    = r_base;
        w_wdata    = '0;

        unique case (r_state)
            S_CLR: begin
                w_we       = 1'b1;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_base = ADDR_W'(32'(w_attr) * BUCKETS);
                    n_high = w_high;
                    n_last = i_s_tlast;
                    n_dq   = {w_low, {SUM_W{1'b0}}};
                    n_dr   = '0;
                    n_dd   = SUM_W'(w_eff_bw);
                    n_dcnt = 6'(VAL_W - 1);
                    if (i_s_tuser == rhsel_pkg::ACT_ADD) begin
                        if (w_attr_ok) begin
                            if (r_total != {SUM_W{1'b1}}) begin
                                n_total = r_total + SUM_W'(1);
                            end
                            n_state = S_DIV_LO;
                        end
                    end else begin
                        n_qhit  = 1'b0;
                        n_state = w_attr_ok ? S_DIV_QI : S_QACC;
                    end
                end
            end
            S_DIV_LO, S_DIV_HI, S_DIV_QI, S_DIV_POS: begin
                n_dq   = {r_dq[DQ_W-2:0], w_ge};
                n_dr   = w_ge ? w_diff[SUM_W-1:0] : w_shl[SUM_W-1:0];
                n_dcnt = r_dcnt - 6'd1;
                if (r_dcnt == '0) begin
                    unique case (r_state)
                        S_DIV_LO: n_state = S_CAP_LO;
                        S_DIV_HI: n_state = S_CAP_HI;
                        S_DIV_QI: n_state = S_QRD;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_CAP_LO: begin
                n_start = w_qidx;
                n_dq    = {r_high, {SUM_W{1'b0}}};
                n_dr    = '0;
                n_dcnt  = 6'(VAL_W - 1);
                n_state = S_DIV_HI;
            end
            S_CAP_HI: begin
                n_end = w_qidx;
                if (r_start > w_qidx) begin
                    n_state = S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_base + ADDR_W'(r_start);
                    n_idx   = r_start;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // Write back the bucket read last cycle, read the next one.
                w_we    = 1'b1;
                w_waddr = r_base + ADDR_W'(r_idx);
                w_wdata = (&r_rd_data) ? r_rd_data : r_rd_data + COUNT_BITS'(1);
                if (r_idx == r_end) begin
                    n_state = S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_base + ADDR_W'(r_idx) + ADDR_W'(1);
                    n_idx   = r_idx + IDX_W'(1);
                end
            end
            S_QRD: begin
                w_re    = 1'b1;
                w_raddr = r_base + ADDR_W'(w_qidx);
                n_qhit  = 1'b1;
                n_state = S_QACC;
            end
            S_QACC: begin
                if (!r_last) begin
                    n_sum   = w_sum_sat;
                    n_state = S_IDLE;
                end else begin
                    n_sum = '0;
                    if (r_total == '0) begin
                        n_zero  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_zero  = 1'b0;
                        n_dq    = {w_sum_sat, {rhsel_pkg::FRAC_W{1'b0}}};
                        n_dr    = '0;
                        n_dd    = r_total;
                        n_dcnt  = 6'(DQ_W - 1);
                        n_state = S_DIV_POS;
                    end
                end
            end
            S_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_pos     = r_zero ? '0 : w_pos_q;
                    n_flag    = r_zero;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_total    <= '0;
            r_sum      <= '0;
            r_m_valid  <= 1'b0;
            r_bw       <= rhsel_pkg::BUCKET_WIDTH_RST;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_total    <= n_total;
            r_sum      <= n_sum;
            r_m_valid  <= n_m_valid;
            if (i_cfg_valid) begin
                r_bw <= i_cfg_data;
            end
        end
        r_base  <= n_base;
        r_high  <= n_high;
        r_last  <= n_last;
        r_qhit  <= n_qhit;
        r_zero  <= n_zero;
        r_start <= n_start;
        r_end   <= n_end;
        r_idx   <= n_idx;
        r_dq    <= n_dq;
        r_dr    <= n_dr;
        r_dd    <= n_dd;
        r_dcnt  <= n_dcnt;
        r_pos   <= n_pos;
        r_flag  <= n_flag;
    end

    // Histogram memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = {{(rhsel_pkg::M_TDATA_W - POS_W){1'b0}}, r_pos};
    assign o_m_tuser   = r_flag;

    // An empty histogram always reports a zero position.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("no_constraints result with nonzero position");

    // No item is taken during the clearing pass.
    a_clr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !o_s_tready)
        else $error("item accepted during clearing pass");

    // The bucket sweep never runs past the end of the interval.
    a_upd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |-> r_idx <= r_end)
        else $error("bucket sweep past interval end");

    // The constraint total never decreases.
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_total >= $past(r_total))
        else $error("constraint total decreased");

endmodule

>>> test/range_histogram_selectivity_tb.sv
module range_histogram_selectivity_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ATTR      = rhsel_pkg::ATTRIBUTES_DEF;
    localparam int NUM_BUCKETS   = rhsel_pkg::BUCKETS_DEF;
    localparam int CNT_W         = rhsel_pkg::COUNT_BITS_DEF;
    localparam int ATTR_BITS     = rhsel_pkg::ATTR_W;
    localparam int VAL_W         = rhsel_pkg::VALUE_W;
    localparam int POS_BITS      = rhsel_pkg::POS_W;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int RUN_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 600;

    // One item on the slave side.
    typedef struct packed {
        logic                 act;
        logic [ATTR_BITS-1:0] attr;
        logic [VAL_W-1:0]     low;
        logic [VAL_W-1:0]     high;
        logic                 last;
    } t_hist_item;

    // One estimate on the master side.
    typedef struct packed {
        logic [POS_BITS-1:0] position;
        logic                no_constraints;
    } t_estimate;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_s_tvalid  = 1'b0;
    logic                            o_s_tready;
    logic [rhsel_pkg::S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                            i_s_tuser   = 1'b0;
    logic                            i_s_tlast   = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready  = 1'b0;
    logic [rhsel_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic                            o_m_tuser;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [VAL_W-1:0]                i_cfg_data  = '0;

    // Histogram state as the block should hold it.
    logic [CNT_W-1:0] hist_count [NUM_ATTR*NUM_BUCKETS];
    logic [31:0]      constraint_total = '0;
    logic [31:0]      query_sum        = '0;
    logic [VAL_W-1:0] width_reg        = rhsel_pkg::BUCKET_WIDTH_RST;
    t_estimate        expected_estimates[$];

    int unsigned error_count   = 0;
    int unsigned hold_request  = 0;
    bit          sender_idle   = 1'b1;
    bit          receiver_idle = 1'b1;

    range_histogram_selectivity #(
        .ATTRIBUTES (NUM_ATTR),
        .BUCKETS    (NUM_BUCKETS),
        .COUNT_BITS (CNT_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Bucket that a value falls in; a zero width counts as one, and the index clamps.
    function automatic int unsigned bucket_of_value(logic [VAL_W-1:0] v);
        int unsigned w;
        int unsigned idx;
        w = (width_reg == '0) ? 1 : width_reg;
        idx = v / w;
        return (idx > NUM_BUCKETS - 1) ? NUM_BUCKETS - 1 : idx;
    endfunction

    // Applies one accepted item to the histogram and queues the estimate it yields.
    function automatic void estimate_selectivity(t_hist_item it);
        int unsigned first_b;
        int unsigned last_b;
        int unsigned base;
        logic [32:0] acc;
        logic [63:0] quotient;
        t_estimate   est;
        base = it.attr * NUM_BUCKETS;
        if (it.act == rhsel_pkg::ACT_ADD) begin
            if (it.attr < NUM_ATTR) begin
                first_b = bucket_of_value(it.low);
                last_b  = bucket_of_value(it.high);
                // An inverted bucket range leaves every bucket alone.
                for (int unsigned b = first_b; b <= last_b; b++) begin
                    if (hist_count[base + b] != '1) begin
                        hist_count[base + b]++;
                    end
                end
                if (constraint_total != '1) begin
                    constraint_total++;
                end
            end
        end else begin
            if (it.attr < NUM_ATTR) begin
                acc = {1'b0, query_sum} + 33'(hist_count[base + bucket_of_value(it.low)]);
                query_sum = acc[32] ? '1 : acc[31:0];
            end
            if (it.last) begin
                if (constraint_total == '0) begin
                    est.position       = '0;
                    est.no_constraints = 1'b1;
                end else begin
                    quotient = {16'b0, query_sum, 16'b0} / {32'b0, constraint_total};
                    est.position       = (quotient > rhsel_pkg::POS_MAX) ?
                                         rhsel_pkg::POS_MAX : quotient[POS_BITS-1:0];
                    est.no_constraints = 1'b0;
                end
                expected_estimates.push_back(est);
                query_sum = '0;
            end
        end
    endfunction

    function automatic t_hist_item hist_item(logic act, logic [ATTR_BITS-1:0] attr,
                                             logic [VAL_W-1:0] low, logic [VAL_W-1:0] high,
                                             logic last);
        t_hist_item it;
        it.act  = act;
        it.attr = attr;
        it.low  = low;
        it.high = high;
        it.last = last;
        return it;
    endfunction

    // Values mostly land inside the bucketed range so the buckets spread out.
    function automatic logic [VAL_W-1:0] random_value();
        int unsigned span;
        span = ((width_reg == '0) ? 1 : width_reg) * NUM_BUCKETS;
        if (span > 65535 || $urandom_range(0, 2) == 0) begin
            return VAL_W'($urandom_range(0, 65535));
        end
        return VAL_W'($urandom_range(0, span));
    endfunction

    // A few attributes get most of the traffic so that queries hit counted buckets.
    function automatic logic [ATTR_BITS-1:0] random_attr();
        if ($urandom_range(0, 3) == 0) begin
            return ATTR_BITS'($urandom_range(0, NUM_ATTR - 1));
        end
        return ATTR_BITS'($urandom_range(0, 3));
    endfunction

    function automatic t_hist_item random_add();
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        a = random_value();
        b = random_value();
        // Mostly ordered intervals, sometimes inverted ones.
        if ($urandom_range(0, 3) != 0 && a > b) begin
            {a, b} = {b, a};
        end
        return hist_item(rhsel_pkg::ACT_ADD, random_attr(), a, b, 1'($urandom_range(0, 1)));
    endfunction

    // Offers one item and waits until the block takes it.
    task automatic send_item(input t_hist_item it);
        @(negedge i_clk);
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.act;
        i_s_tlast  <= it.last;
        i_s_tdata  <= {{(rhsel_pkg::S_TDATA_W - 2*VAL_W - ATTR_BITS){1'b0}},
                       it.high, it.low, it.attr};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        estimate_selectivity(it);
    endtask

    // Stops offering items, lets every estimate arrive, then lets any add finish.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_estimates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bucket_width(input logic [VAL_W-1:0] w);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        width_reg = w;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A query before any constraint exists reports the empty flag.
    task automatic test_empty_histogram();
        send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd0, 16'h0000, 16'h0000, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, ATTR_BITS'(NUM_ATTR - 1),
                            16'hFFFF, 16'hFFFF, 1'b1));
        wait_idle();
    endtask

    // Two full-range constraints and 65 pairs push the ratio past the position range.
    task automatic test_position_saturation();
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd9, 16'h0000, 16'hFFFF, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd9, 16'h0000, 16'hFFFF, 1'b0));
        for (int k = 1; k <= 65; k++) begin
            send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd9, VAL_W'($urandom_range(0, 65535)),
                                VAL_W'($urandom_range(0, 65535)), k == 65));
        end
        wait_idle();
    endtask

    // Field extremes and an inverted interval at the reset width.
    task automatic test_range_extremes();
        send_item(hist_item(rhsel_pkg::ACT_ADD, ATTR_BITS'(NUM_ATTR - 1),
                            16'hFFFF, 16'hFFFF, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd0, 16'h0000, 16'h0000, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd5, 16'd40000, 16'd1000, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd5, 16'd1023, 16'd1024, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd21, 16'h5555, 16'hAAAA, 1'b1));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, ATTR_BITS'(NUM_ATTR - 1),
                            16'hFFFF, 16'h0000, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd0, 16'h0000, 16'hFFFF, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd5, 16'd1024, 16'h0000, 1'b1));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd5, 16'd40000, 16'h0000, 1'b1));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd21, 16'hAAAA, 16'h5555, 1'b1));
        wait_idle();
    endtask

    // Zero width, widest width and narrowest width, where most indexes clamp.
    task automatic test_width_corners();
        write_bucket_width(16'd0);
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd3, 16'd5, 16'd9, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd3, 16'd10, 16'hFFFF, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd3, 16'd100, 16'd50, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd3, 16'd7, 16'h0000, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd3, 16'd63, 16'h0000, 1'b1));
        wait_idle();
        write_bucket_width(16'hFFFF);
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd4, 16'hFFFE, 16'hFFFF, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd4, 16'hFFFF, 16'h0000, 1'b1));
        wait_idle();
        write_bucket_width(16'd1);
        send_item(hist_item(rhsel_pkg::ACT_ADD, 5'd6, 16'd62, 16'd64, 1'b0));
        send_item(hist_item(rhsel_pkg::ACT_QUERY, 5'd6, 16'd63, 16'h0000, 1'b1));
        wait_idle();
        write_bucket_width(rhsel_pkg::BUCKET_WIDTH_RST);
    endtask

    // The receiver holds off for a long stretch while queries keep coming.
    task automatic test_output_backpressure();
        sender_idle  = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 12; k++) begin
            send_item(hist_item(rhsel_pkg::ACT_QUERY, random_attr(), random_value(),
                                VAL_W'($urandom_range(0, 65535)), 1'b1));
        end
        wait_idle();
        sender_idle = 1'b1;
    endtask

    // One add, or one query of a few pairs with an add now and then in between.
    task automatic send_random_burst(inout int unsigned sent);
        int unsigned pairs;
        if ($urandom_range(0, 9) < 5) begin
            send_item(random_add());
            sent++;
        end else begin
            pairs = $urandom_range(1, 6);
            for (int unsigned k = 1; k <= pairs; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(random_add());
                    sent++;
                end
                send_item(hist_item(rhsel_pkg::ACT_QUERY, random_attr(), random_value(),
                                    VAL_W'($urandom_range(0, 65535)), k == pairs));
                sent++;
            end
        end
    endtask

    // Random traffic over several widths; the last phase runs without idling.
    task automatic test_random_traffic();
        logic [VAL_W-1:0] w;
        int unsigned sent;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: w = rhsel_pkg::BUCKET_WIDTH_RST;
                1: w = VAL_W'($urandom_range(1, 2047));
                2: w = VAL_W'($urandom_range(2048, 65535));
                3: w = '0;
                4: w = VAL_W'($urandom_range(256, 1200));
                default: begin
                    w = rhsel_pkg::BUCKET_WIDTH_RST;
                    sender_idle   = 1'b0;
                    receiver_idle = 1'b0;
                end
            endcase
            write_bucket_width(w);
            sent = 0;
            while (sent < PHASE_ITEMS) send_random_burst(sent);
            wait_idle();
        end
    endtask

    // Receiver: random stalls, plus the long hold-off when one is requested.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Each estimate taken from the block is matched against the oldest one queued.
    always @(posedge i_clk) begin
        t_estimate want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_estimates.size() == 0) begin
                $error("unexpected estimate: position %0d, no_constraints %0b",
                       o_m_tdata[POS_BITS-1:0], o_m_tuser);
                error_count++;
            end else begin
                want = expected_estimates.pop_front();
                if (o_m_tdata[POS_BITS-1:0] !== want.position) begin
                    $error("position: expected %0d, got %0d",
                           want.position, o_m_tdata[POS_BITS-1:0]);
                    error_count++;
                end
                if (o_m_tuser !== want.no_constraints) begin
                    $error("no_constraints: expected %0b, got %0b",
                           want.no_constraints, o_m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Run limit.
    initial begin
        for (int c = 0; c < RUN_LIMIT; c++) @(posedge i_clk);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        foreach (hist_count[i]) hist_count[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_histogram();
        test_position_saturation();
        test_range_extremes();
        test_width_corners();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();

        if (error_count == 0 && expected_estimates.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
